// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/crcdfr_pkg.sv =====
`timescale 1ns / 1ps

package crcdfr_pkg;

  localparam int BUFFER_DEPTH = 32;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam logic [5:0] LEN_LIMIT = 6'((BUFFER_DEPTH < 32) ? BUFFER_DEPTH : 32);
  localparam logic [5:0] LEN_MIN   = 6'd2;

  typedef enum logic [1:0] {
    ST_RX,
    ST_READ,
    ST_LOAD
  } dfr_state_e;

  typedef enum logic [2:0] {
    REG_CRC_POLY     = 3'd0,
    REG_CRC_INIT     = 3'd1,
    REG_GAMEPAD_HDR  = 3'd2,
    REG_GAMEPAD_LEN  = 3'd3,
    REG_CODE_HDR     = 3'd4,
    REG_CODE_LEN     = 3'd5
  } reg_idx_e;

  localparam logic [7:0] RST_CRC_POLY    = 8'h07;
  localparam logic [7:0] RST_CRC_INIT    = 8'hFF;
  localparam logic [7:0] RST_GAMEPAD_HDR = 8'hA6;
  localparam logic [5:0] RST_GAMEPAD_LEN = 6'd23;
  localparam logic [7:0] RST_CODE_HDR    = 8'hA7;
  localparam logic [5:0] RST_CODE_LEN    = 6'd6;

  // MSB-first CRC-8, one byte
  function automatic logic [7:0] crc8_fold(logic [7:0] crc, logic [7:0] b, logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [5:0] clamp_len(logic [5:0] len);
    logic [5:0] v;
    v = len;
    if (v < LEN_MIN) begin
      v = LEN_MIN;
    end
    if (v > LEN_LIMIT) begin
      v = LEN_LIMIT;
    end
    return v;
  endfunction

endpackage

// ===== hdl/crc8_checked_packet_deframer.sv =====
`timescale 1ns / 1ps
// Header-framed packet receiver with CRC-8 check.
// Input channel (rx_valid_i/rx_ready_o, rx_byte_i): one received byte per beat.
// While hunting, bytes that match neither header are dropped. A header picks
// the packet type and total length; bytes go into a single-port 8-bit buffer
// and a running CRC-8 (polynomial and seed from the APB registers).
// rx_ready_o stays high while header and body bytes are received.
// The final byte is the CRC. On a match with a total length above two, the
// payload bytes are read back from the buffer and sent on the output channel
// (out_valid_o/out_ready_i) with type, position and last flag; else dropped.
// Payload readout, per beat: buffer read, then output register load. After
// the CRC beat the first beat takes both steps. rx_ready_o is low during
// readout and rises once the last beat sits in the output register.
// A stalled receiver holds the output register; readout waits for it.
// Reset: hunting, registers at their defaults, output empty. The buffer is
// not cleared; entries are always written before they are read.
`include "assert_macros.svh"

module crc8_checked_packet_deframer import crcdfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        packet_type_o,
  output logic [4:0]  byte_position_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_o
);

  logic [7:0] crc_poly_q, crc_init_q, gamepad_hdr_q, code_hdr_q;
  logic [5:0] gamepad_len_q, code_len_q;

  dfr_state_e state_q, state_d;
  logic [5:0] fill_q, fill_d;
  logic [5:0] target_q, target_d;
  logic       type_q, type_d;
  logic [7:0] crc_q, crc_d;
  logic [4:0] idx_q, idx_d;
  logic [4:0] idx_last_q, idx_last_d;

  logic [7:0] mem_q [BUFFER_DEPTH];
  logic [7:0] rdata_q;
  logic       wr_en, rd_en, out_load;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [8:0] wr_addr_ext, rd_addr_ext;

  logic       out_valid_q;
  logic       out_type_q, out_last_q;
  logic [4:0] out_pos_q;
  logic [7:0] out_byte_q;

  logic       rx_fire, cfg_wr;
  logic [2:0] cfg_idx;
  logic [7:0] crc_next;
  logic [5:0] fill_inc;
  logic [5:0] tlen_m3;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_poly_q    <= RST_CRC_POLY;
      crc_init_q    <= RST_CRC_INIT;
      gamepad_hdr_q <= RST_GAMEPAD_HDR;
      gamepad_len_q <= RST_GAMEPAD_LEN;
      code_hdr_q    <= RST_CODE_HDR;
      code_len_q    <= RST_CODE_LEN;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CRC_POLY:    crc_poly_q    <= pwdata[7:0];
        REG_CRC_INIT:    crc_init_q    <= pwdata[7:0];
        REG_GAMEPAD_HDR: gamepad_hdr_q <= pwdata[7:0];
        REG_GAMEPAD_LEN: gamepad_len_q <= pwdata[5:0];
        REG_CODE_HDR:    code_hdr_q    <= pwdata[7:0];
        REG_CODE_LEN:    code_len_q    <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CRC_POLY:    prdata = {24'd0, crc_poly_q};
      REG_CRC_INIT:    prdata = {24'd0, crc_init_q};
      REG_GAMEPAD_HDR: prdata = {24'd0, gamepad_hdr_q};
      REG_GAMEPAD_LEN: prdata = {26'd0, gamepad_len_q};
      REG_CODE_HDR:    prdata = {24'd0, code_hdr_q};
      REG_CODE_LEN:    prdata = {26'd0, code_len_q};
      default:         prdata = 32'd0;
    endcase
  end

  assign rx_ready_o = (state_q == ST_RX);
  assign rx_fire    = rx_valid_i && rx_ready_o;
  assign fill_inc   = fill_q + 6'd1;
  assign tlen_m3    = target_q - 6'd3;

  assign wr_addr_ext = {3'd0, fill_q};
  assign wr_addr     = wr_addr_ext[ADDR_W-1:0];
  assign rd_addr_ext = {4'd0, idx_q} + 9'd1;
  assign rd_addr     = rd_addr_ext[ADDR_W-1:0];

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    target_d   = target_q;
    type_d     = type_q;
    crc_d      = crc_q;
    idx_d      = idx_q;
    idx_last_d = idx_last_q;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    crc_next   = crc8_fold(crc_q, rx_byte_i, crc_poly_q);
    unique case (state_q)
      ST_RX: begin
        if (rx_fire) begin
          if (fill_q == 6'd0) begin
            priority if (rx_byte_i == gamepad_hdr_q) begin
              type_d   = 1'b0;
              target_d = clamp_len(gamepad_len_q);
              fill_d   = 6'd1;
              wr_en    = 1'b1;
              crc_d    = crc8_fold(crc_init_q, rx_byte_i, crc_poly_q);
            end else if (rx_byte_i == code_hdr_q) begin
              type_d   = 1'b1;
              target_d = clamp_len(code_len_q);
              fill_d   = 6'd1;
              wr_en    = 1'b1;
              crc_d    = crc8_fold(crc_init_q, rx_byte_i, crc_poly_q);
            end else begin
            end
          end else if (fill_inc < target_q) begin
            wr_en  = 1'b1;
            crc_d  = crc_next;
            fill_d = fill_inc;
          end else begin
            fill_d   = 6'd0;
            target_d = 6'd0;
            if ((crc_q == rx_byte_i) && (target_q > LEN_MIN)) begin
              idx_d      = 5'd0;
              idx_last_d = tlen_m3[4:0];
              state_d    = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        rd_en   = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          idx_d    = idx_q + 5'd1;
          state_d  = (idx_q == idx_last_q) ? ST_RX : ST_READ;
        end
      end
      default: state_d = ST_RX;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RX;
      fill_q     <= 6'd0;
      target_q   <= 6'd0;
      type_q     <= 1'b0;
      crc_q      <= RST_CRC_INIT;
      idx_q      <= 5'd0;
      idx_last_q <= 5'd0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      target_q   <= target_d;
      type_q     <= type_d;
      crc_q      <= crc_d;
      idx_q      <= idx_d;
      idx_last_q <= idx_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= rx_byte_i;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_type_q <= type_q;
      out_pos_q  <= idx_q;
      out_byte_q <= rdata_q;
      out_last_q <= (idx_q == idx_last_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign packet_type_o   = out_type_q;
  assign byte_position_o = out_pos_q;
  assign payload_byte_o  = out_byte_q;
  assign last_o          = out_last_q;

  `ASSERT_IMPL(a_fill_below_target, fill_q != 6'd0, fill_q < target_q, "fill reached target")
  `ASSERT_IMPL(a_readout_hunting, state_q != ST_RX, fill_q == 6'd0, "packet fill during readout")
  `ASSERT_IMPL(a_idx_in_range, state_q == ST_READ, idx_q <= idx_last_q, "readout index overrun")
  `ASSERT_NEXT(a_last_to_rx, out_load && (idx_q == idx_last_q), state_q == ST_RX, "readout not ended")

endmodule
